@@ hw/rtl/tccw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, request codes and controller/datapath interface types
// for the text console cursor writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int REQ_W  = 2;

  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_DOLLAR    = 8'h24;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [COL_W-1:0]  PROMPT_COL   = 7'd2;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h02;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0220;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELL_COUNT - 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT    = 2'd0,
    REQ_COLOR  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_UNUSED = 2'd3
  } tccw_req_t;

  typedef struct packed {
    logic load;     // capture input beat
    logic exec;     // carry out the captured request
    logic clear;    // one step of the screen clear sweep
    logic prompt1;  // store '$' at column 0
    logic prompt2;  // store ' ' at column 1
    logic finish;   // load the output register
  } tccw_cmd_t;

  typedef struct packed {
    logic overflow;   // request runs past the last row
    logic newline;
    logic prompt_en;
    logic clear_last;
    logic out_free;
  } tccw_status_t;

endpackage

@@ hw/rtl/tccw_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer for the console writer: clear sweep, request execution, prompt
// writes and result hand-off.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  tccw_pkg::tccw_status_t st,
  output tccw_pkg::tccw_cmd_t   cmd
);
  import tccw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_PROMPT1,
    ST_PROMPT2,
    ST_FINISH
  } state_t;

  state_t state_r;
  logic   prompt_pend_r;
  logic   boot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      prompt_pend_r <= 1'b0;
      boot_r        <= 1'b1;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (st.clear_last) begin
            boot_r        <= 1'b0;
            prompt_pend_r <= 1'b0;
            if (boot_r) begin
              state_r <= ST_IDLE;
            end else if (prompt_pend_r) begin
              state_r <= ST_PROMPT1;
            end else begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (st.overflow) begin
            state_r       <= ST_CLEAR;
            prompt_pend_r <= st.newline & st.prompt_en;
          end else if (st.newline && st.prompt_en) begin
            state_r <= ST_PROMPT1;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_PROMPT1: state_r <= ST_PROMPT2;
        ST_PROMPT2: state_r <= ST_FINISH;
        ST_FINISH: begin
          if (st.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    in_tready   = (state_r == ST_IDLE);
    cmd.load    = (state_r == ST_IDLE) & in_tvalid;
    cmd.exec    = (state_r == ST_EXEC);
    cmd.clear   = (state_r == ST_CLEAR);
    cmd.prompt1 = (state_r == ST_PROMPT1);
    cmd.prompt2 = (state_r == ST_PROMPT2);
    cmd.finish  = (state_r == ST_FINISH) & st.out_free;
  end

endmodule

@@ hw/rtl/tccw_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_datapath
// Screen cell memory, cursor and attribute registers, request capture and
// the output register.
// ----------------------------------------------------------------------------
module tccw_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tccw_pkg::tccw_cmd_t               cmd,
  output tccw_pkg::tccw_status_t            st,
  input  logic [tccw_pkg::REQ_W-1:0]        in_req,
  input  logic [tccw_pkg::CHAR_W-1:0]       in_char,
  input  logic [tccw_pkg::ATTR_W-1:0]       in_color,
  input  logic [tccw_pkg::IDX_W-1:0]        in_cell,
  input  logic                              cfg_wr,
  input  logic                              cfg_welcome,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tccw_pkg::CELL_W-1:0]       out_read_data,
  output logic [tccw_pkg::ROW_W-1:0]        out_row,
  output logic [tccw_pkg::COL_W-1:0]        out_col
);
  import tccw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  tccw_req_t         req_r;
  logic [CHAR_W-1:0] char_r;
  logic [ATTR_W-1:0] color_r;
  logic [IDX_W-1:0]  cell_r;

  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [ATTR_W-1:0] attr_r;
  logic              welcome_r;
  logic [IDX_W-1:0]  clr_cnt_r;

  logic [CELL_W-1:0] rd_data_r;
  logic              rd_oor_r;

  logic              out_valid_r;
  logic [CELL_W-1:0] out_data_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;

  logic              is_put, is_newline, is_nul, is_bs, is_plain;
  logic              bs_step;
  logic [IDX_W-1:0]  cur_idx;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;

  assign is_put     = (req_r == REQ_PUT);
  assign is_newline = is_put && (char_r == CH_NEWLINE);
  assign is_nul     = is_put && (char_r == CH_NUL);
  assign is_bs      = is_put && (char_r == CH_BACKSPACE);
  assign is_plain   = is_put && !is_newline && !is_nul && !is_bs;
  assign bs_step    = col_r > PROMPT_COL;

  assign cur_idx = row_r * IDX_W'(SCREEN_COLUMNS) + IDX_W'(col_r);

  assign st.newline    = is_newline;
  assign st.prompt_en  = !welcome_r;
  assign st.clear_last = (clr_cnt_r == LAST_IDX);
  assign st.out_free   = !out_valid_r || out_ready;
  assign st.overflow   = (row_r == LAST_ROW) &&
                         (is_newline || (is_plain && (col_r == LAST_COL)));

  // single write port shared by sweep, put, backspace and prompt
  always_comb begin
    we    = 1'b0;
    waddr = cur_idx;
    wdata = {attr_r, char_r};
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = BLANK_CELL;
    end else if (cmd.prompt1) begin
      we    = 1'b1;
      wdata = {attr_r, CH_DOLLAR};
    end else if (cmd.prompt2) begin
      we    = 1'b1;
      wdata = {attr_r, CH_SPACE};
    end else if (cmd.exec && is_plain) begin
      we = 1'b1;
    end else if (cmd.exec && is_bs && bs_step) begin
      we    = 1'b1;
      waddr = cur_idx - IDX_W'(1);
      wdata = {attr_r, CH_NUL};
    end
  end

  assign re = cmd.exec && (req_r == REQ_READ);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[cell_r];
      rd_oor_r  <= (cell_r > LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= tccw_req_t'(in_req);
      char_r  <= in_char;
      color_r <= in_color;
      cell_r  <= in_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      attr_r    <= RESET_ATTR;
      welcome_r <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_wr) begin
        welcome_r <= cfg_welcome;
      end
      if (cmd.clear) begin
        if (st.clear_last) begin
          clr_cnt_r <= '0;
          row_r     <= '0;
          col_r     <= '0;
          attr_r    <= RESET_ATTR;
        end else begin
          clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        end
      end else if (cmd.prompt1) begin
        col_r <= COL_W'(1);
      end else if (cmd.prompt2) begin
        col_r <= PROMPT_COL;
      end else if (cmd.exec && !st.overflow) begin
        // on overflow the sweep homes the cursor
        if (req_r == REQ_COLOR) begin
          attr_r <= color_r;
        end else if (is_newline) begin
          col_r <= '0;
          row_r <= row_r + ROW_W'(1);
        end else if (is_bs) begin
          col_r <= bs_step ? col_r - COL_W'(1) : PROMPT_COL;
        end else if (is_plain) begin
          if (col_r == LAST_COL) begin
            col_r <= '0;
            row_r <= row_r + ROW_W'(1);
          end else begin
            col_r <= col_r + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= ((req_r == REQ_READ) && !rd_oor_r) ? rd_data_r : '0;
      out_row_r  <= row_r;
      out_col_r  <= col_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;

endmodule

@@ hw/rtl/text_console_cursor_writer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_writer_top
// Character-cell console: 80x25 cell store with cursor, current attribute,
// prompt-on-newline option and cell readback.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole cell store to blank green-on-black,
// one cell per cycle with in_tready low; the same sweep runs whenever a
// newline or a line wrap passes the last row, inside that item.
// Otherwise an item goes through accept, execute on the single memory port
// and output load, which waits for a free output register; a newline that
// writes the prompt adds a state per prompt character, each a memory write.
// The output register lets the next item be accepted while a result waits.
// The configuration register is taken at any time with cfg_ready high.
module text_console_cursor_writer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[7:0], color_value[15:8], cell_index[26:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data[15:0], cursor_row[20:16], cursor_column[27:21]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // welcome_mode[0]
);
  import tccw_pkg::*;

  tccw_cmd_t         cmd;
  tccw_status_t      st;
  logic [CELL_W-1:0] out_read_data;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;

  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tccw_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_req        (in_tuser),
    .in_char       (in_tdata[7:0]),
    .in_color      (in_tdata[15:8]),
    .in_cell       (in_tdata[26:16]),
    .cfg_wr        (cfg_valid & cfg_ready),
    .cfg_welcome   (cfg_data[0]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_read_data (out_read_data),
    .out_row       (out_row),
    .out_col       (out_col)
  );

  assign out_tdata = {4'b0000, out_col, out_row, out_read_data};

endmodule
